/* hdl/rth_pkg.sv */
package rth_pkg;

  // default channel width
  localparam int unsigned CHANNEL_BITS_DEF = 8;

  // quotient bits of both dividers, one bit resolved per pipeline stage
  localparam int unsigned DIV_BITS = 16;

  localparam int unsigned HUE_BITS = 13;
  localparam int unsigned SAT_BITS = 16;

  // 60 degrees in sixteenths of a degree
  localparam logic [9:0] HUE_SIXTH = 10'd960;

  localparam logic [HUE_BITS-1:0] HUE_RED_BASE   = 13'd0;
  localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = 13'd1920;
  localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE  = 13'd3840;
  localparam logic [HUE_BITS-1:0] HUE_FULL       = 13'd5760;

  // which sextant offset the hue starts from
  typedef enum logic [1:0] {
    HB_RED,
    HB_RED_WRAP,
    HB_GREEN,
    HB_BLUE
  } hue_base_e;

  function automatic logic [HUE_BITS-1:0] hue_base(input hue_base_e sel);
    logic [HUE_BITS-1:0] base;
    case (sel)
      HB_RED:      base = HUE_RED_BASE;
      HB_RED_WRAP: base = HUE_FULL;
      HB_GREEN:    base = HUE_GREEN_BASE;
      HB_BLUE:     base = HUE_BLUE_BASE;
      default:     base = HUE_RED_BASE;
    endcase
    return base;
  endfunction

endpackage

/* hdl/rgb_to_hsl.sv */
// rgb to hsl converter, fully pipelined: one pixel beat is taken every clock while the output
// is not stalled. the pipeline is built around the two 16-stage restoring dividers (saturation
// and hue), which resolve one quotient bit per stage; an input register, a max/min stage, a
// scaling stage and the output register add four more. a stall at the output only holds the
// stages that are full, so bubbles are squeezed out and the input keeps taking beats while the
// pipeline has room. lightness comes out as max + min (divide by 2*(2^CHANNEL_BITS-1) for the
// real value), saturation scaled so 65535 means one, hue in sixteenths of a degree (0..5759). a
// grey pixel gives hue and saturation zero.
module rgb_to_hsl #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // red, green, blue from the lowest bit up, zero padded to whole bytes
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // hue (13), saturation (16), lightness_sum (CHANNEL_BITS+1) from the lowest bit up, zero padded
  output logic [((rth_pkg::HUE_BITS+rth_pkg::SAT_BITS+CHANNEL_BITS+1+7)/8)*8-1:0] m_axis_tdata_o
);
  import rth_pkg::*;

  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned NW    = CB + DIV_BITS;
  localparam int unsigned OUT_W = ((HUE_BITS + SAT_BITS + CB + 1 + 7) / 8) * 8;
  localparam int unsigned PAD_W = OUT_W - (HUE_BITS + SAT_BITS + CB + 1);
  // side info riding along the dividers: lightness sum, subtract flag, base select, grey
  localparam int unsigned SW    = CB + 1 + 1 + 2 + 1;

  localparam logic [CB-1:0] CHAN_MAX = {CB{1'b1}};
  localparam logic [CB:0]   TWO_MAX  = {CHAN_MAX, 1'b0};

  // stage a: input register
  logic          va_q;
  logic [CB-1:0] r_q, g_q, b_q;
  logic          en_a, en_b, en_c, en_o;

  // stage b: max/min, sextant and difference
  logic          vb_q;
  logic [CB-1:0] b_delta_q, b_den_q, b_diff_q;
  logic [CB:0]   b_sum_q;
  logic          b_neg_q, b_grey_q;
  hue_base_e     b_sel_q;

  logic [CB-1:0] mx, mn, delta_d, den_d, diff_d, sa, sb;
  logic [CB:0]   sum_d, den_full;
  logic          neg_d;
  hue_base_e     sel_d;

  // stage c: numerator scaling
  logic          vc_q;
  logic [NW-1:0] c_snum_q, c_hnum_q;
  logic [CB-1:0] c_sden_q, c_hden_q;
  logic [SW-1:0] c_side_q;

  // divider handshake
  logic                div_in_ready, div_out_valid;
  logic [DIV_BITS-1:0] sat_quo, hue_quo;
  logic [SW-1:0]       div_side;

  // output register
  logic                ov_q;
  logic [HUE_BITS-1:0] hue_q, hue_d;
  logic [SAT_BITS-1:0] sat_q;
  logic [CB:0]         lsum_q;
  logic                o_grey, o_neg;
  hue_base_e           o_sel;
  logic [CB:0]         o_sum;

  assign en_o = !ov_q || m_axis_tready_i;
  assign en_c = !vc_q || div_in_ready;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign s_axis_tready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      r_q <= s_axis_tdata_i[CB-1:0];
      g_q <= s_axis_tdata_i[2*CB-1:CB];
      b_q <= s_axis_tdata_i[3*CB-1:2*CB];
    end
  end

  // max/min with blue over green over red on a tie for the maximum
  always_comb begin
    mx = r_q;
    mn = r_q;
    if (g_q > mx) mx = g_q;
    if (b_q > mx) mx = b_q;
    if (g_q < mn) mn = g_q;
    if (b_q < mn) mn = b_q;
    delta_d  = mx - mn;
    sum_d    = {1'b0, mx} + {1'b0, mn};
    den_full = TWO_MAX - sum_d;
    den_d    = (sum_d <= {1'b0, CHAN_MAX}) ? sum_d[CB-1:0] : den_full[CB-1:0];

    if (b_q == mx) begin
      sel_d = HB_BLUE;
      sa    = r_q;
      sb    = g_q;
    end else if (g_q == mx) begin
      sel_d = HB_GREEN;
      sa    = b_q;
      sb    = r_q;
    end else if (g_q >= b_q) begin
      sel_d = HB_RED;
      sa    = g_q;
      sb    = b_q;
    end else begin
      sel_d = HB_RED_WRAP;
      sa    = g_q;
      sb    = b_q;
    end
    // negative offsets use a ceiling quotient, then subtract from the base
    neg_d  = sa < sb;
    diff_d = neg_d ? sb - sa : sa - sb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_delta_q <= delta_d;
      b_den_q   <= den_d;
      b_diff_q  <= diff_d;
      b_sum_q   <= sum_d;
      b_neg_q   <= neg_d;
      b_grey_q  <= delta_d == '0;
      b_sel_q   <= sel_d;
    end
  end

  // 65535*delta as a shift and subtract; 960*diff plus delta-1 for a ceiling on negatives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_snum_q <= {b_delta_q, {DIV_BITS{1'b0}}} - {{DIV_BITS{1'b0}}, b_delta_q};
      c_hnum_q <= {{DIV_BITS{1'b0}}, b_diff_q} * {{(NW-10){1'b0}}, HUE_SIXTH}
                + (b_neg_q ? {{DIV_BITS{1'b0}}, b_delta_q - 1'b1} : '0);
      c_sden_q <= b_den_q;
      c_hden_q <= b_delta_q;
      c_side_q <= {b_grey_q, b_sel_q, b_neg_q, b_sum_q};
    end
  end

  rth_div #(
    .CHANNEL_BITS (CB),
    .SIDE_BITS    (SW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vc_q),
    .in_ready_o  (div_in_ready),
    .sat_num_i   (c_snum_q),
    .sat_den_i   (c_sden_q),
    .hue_num_i   (c_hnum_q),
    .hue_den_i   (c_hden_q),
    .side_i      (c_side_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (en_o),
    .sat_quo_o   (sat_quo),
    .hue_quo_o   (hue_quo),
    .side_o      (div_side)
  );

  assign o_grey = div_side[SW-1];
  assign o_sel  = hue_base_e'(div_side[SW-2:SW-3]);
  assign o_neg  = div_side[CB+1];
  assign o_sum  = div_side[CB:0];

  always_comb begin
    if (o_grey) begin
      hue_d = '0;
    end else if (o_neg) begin
      hue_d = hue_base(o_sel) - hue_quo[HUE_BITS-1:0];
    end else begin
      hue_d = hue_base(o_sel) + hue_quo[HUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      hue_q  <= hue_d;
      sat_q  <= o_grey ? '0 : sat_quo;
      lsum_q <= o_sum;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, lsum_q, sat_q, hue_q};

`ifndef SYNTHESIS
  // hue always wraps into one turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> hue_q < HUE_FULL)
    else $error("hue out of range");

  // lightness sum never exceeds twice the channel maximum
  a_lsum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> lsum_q <= TWO_MAX)
    else $error("lightness sum out of range");

  // a pixel with nonzero hue always has nonzero saturation
  a_hue_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && hue_q != '0) |-> sat_q != '0)
    else $error("hue without saturation");

  // the input only stalls when the output holds a beat that is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (ov_q && !m_axis_tready_i))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

/* hdl/rth_div.sv */
module rth_div #(
  parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned SIDE_BITS    = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [CHANNEL_BITS+rth_pkg::DIV_BITS-1:0] sat_num_i,
  input  logic [CHANNEL_BITS-1:0]            sat_den_i,
  input  logic [CHANNEL_BITS+rth_pkg::DIV_BITS-1:0] hue_num_i,
  input  logic [CHANNEL_BITS-1:0]            hue_den_i,
  input  logic [SIDE_BITS-1:0]               side_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rth_pkg::DIV_BITS-1:0]       sat_quo_o,
  output logic [rth_pkg::DIV_BITS-1:0]       hue_quo_o,
  output logic [SIDE_BITS-1:0]               side_o
);
  import rth_pkg::*;

  localparam int unsigned NW = CHANNEL_BITS + DIV_BITS;

  logic [NW-1:0]           srem_q [DIV_BITS];
  logic [DIV_BITS-1:0]     squo_q [DIV_BITS];
  logic [CHANNEL_BITS-1:0] sden_q [DIV_BITS];
  logic [NW-1:0]           hrem_q [DIV_BITS];
  logic [DIV_BITS-1:0]     hquo_q [DIV_BITS];
  logic [CHANNEL_BITS-1:0] hden_q [DIV_BITS];
  logic [SIDE_BITS-1:0]    side_q [DIV_BITS];
  logic [DIV_BITS-1:0]     v_q;
  logic [DIV_BITS:0]       en;

  assign en[DIV_BITS] = out_ready_i;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [NW-1:0]           srem_in, hrem_in, strial, htrial, srem_d, hrem_d;
    logic [DIV_BITS-1:0]     squo_in, hquo_in;
    logic [CHANNEL_BITS-1:0] sden_in, hden_in;
    logic [SIDE_BITS-1:0]    side_in;
    logic                    vin, sge, hge;

    if (k == 0) begin : g_first
      assign vin     = in_valid_i;
      assign srem_in = sat_num_i;
      assign hrem_in = hue_num_i;
      assign squo_in = '0;
      assign hquo_in = '0;
      assign sden_in = sat_den_i;
      assign hden_in = hue_den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = v_q[k-1];
      assign srem_in = srem_q[k-1];
      assign hrem_in = hrem_q[k-1];
      assign squo_in = squo_q[k-1];
      assign hquo_in = hquo_q[k-1];
      assign sden_in = sden_q[k-1];
      assign hden_in = hden_q[k-1];
      assign side_in = side_q[k-1];
    end

    // restoring step for quotient bit DIV_BITS-1-k
    assign strial = {{DIV_BITS{1'b0}}, sden_in} << (DIV_BITS - 1 - k);
    assign htrial = {{DIV_BITS{1'b0}}, hden_in} << (DIV_BITS - 1 - k);
    assign sge    = srem_in >= strial;
    assign hge    = hrem_in >= htrial;
    assign srem_d = sge ? srem_in - strial : srem_in;
    assign hrem_d = hge ? hrem_in - htrial : hrem_in;

    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        srem_q[k] <= srem_d;
        hrem_q[k] <= hrem_d;
        squo_q[k] <= {squo_in[DIV_BITS-2:0], sge};
        hquo_q[k] <= {hquo_in[DIV_BITS-2:0], hge};
        sden_q[k] <= sden_in;
        hden_q[k] <= hden_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[DIV_BITS-1];
  assign sat_quo_o   = squo_q[DIV_BITS-1];
  assign hue_quo_o   = hquo_q[DIV_BITS-1];
  assign side_o      = side_q[DIV_BITS-1];

endmodule
